FILE: rtl/core/amx_pkg.sv
// ============================================================================
// amx_pkg
// shared types and constants of the accumulator machine executor
// ============================================================================
`default_nettype none

package amx_pkg;

  localparam int MEM_WORDS  = 256;
  localparam int ADDR_BITS  = $clog2(MEM_WORDS);
  localparam int DATA_BITS  = 32;
  localparam int PC_BITS    = 16;
  localparam int QDEPTH     = 2;
  localparam int QPTR_BITS  = $clog2(QDEPTH);
  localparam int QCNT_BITS  = $clog2(QDEPTH + 1);

  localparam logic [3:0] CMD_SET   = 4'd0;
  localparam logic [3:0] CMD_LDR   = 4'd1;
  localparam logic [3:0] CMD_ADD   = 4'd2;
  localparam logic [3:0] CMD_INC   = 4'd3;
  localparam logic [3:0] CMD_DEC   = 4'd4;
  localparam logic [3:0] CMD_STR   = 4'd5;
  localparam logic [3:0] CMD_SHW   = 4'd6;
  localparam logic [3:0] CMD_PAUSE = 4'd7;
  localparam logic [3:0] CMD_END   = 4'd8;

  localparam logic [1:0] SEL_ACC = 2'd0;
  localparam logic [1:0] SEL_MAR = 2'd1;
  localparam logic [1:0] SEL_MDR = 2'd2;
  localparam logic [1:0] SEL_MEM = 2'd3;

  localparam logic [1:0] CNT_TWO   = 2'd2;
  localparam logic [1:0] CNT_THREE = 2'd3;

  typedef enum logic [3:0] {
    OP_SET,
    OP_LDR,
    OP_ADD1,
    OP_ADD2,
    OP_ADD3,
    OP_INC,
    OP_DEC,
    OP_STR,
    OP_SHW_ACC,
    OP_SHW_MAR,
    OP_SHW_MDR,
    OP_SHW_MEM,
    OP_END,
    OP_NOP
  } op_t;

  typedef enum logic {
    BK_IDLE,
    BK_EXEC
  } bk_state_t;

  typedef struct packed {
    logic [3:0]                  cmd;
    logic [7:0]                  addr_a;
    logic [7:0]                  addr_b;
    logic [7:0]                  addr_c;
    logic [1:0]                  operand_count;
    logic signed [DATA_BITS-1:0] immediate;
    logic [1:0]                  show_select;
    logic                        program_start;
  } instr_t;

  typedef struct packed {
    logic signed [DATA_BITS-1:0] accumulator;
    logic [7:0]                  address_reg;
    logic signed [DATA_BITS-1:0] data_reg;
    logic                        show_valid;
    logic signed [DATA_BITS-1:0] show_value;
    logic                        halted;
    logic [PC_BITS-1:0]          instr_count;
  } result_t;

  typedef struct packed {
    op_t                  op;
    logic [7:0]           addr_a;
    logic [7:0]           addr_b;
    logic [7:0]           addr_c;
    logic [DATA_BITS-1:0] immediate;
    logic                 start;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } q_head_t;

endpackage

`default_nettype wire

FILE: rtl/core/accumulator_machine_executor_core.sv
// ============================================================================
// accumulator_machine_executor_core
// accumulator machine executing one decoded instruction per word
// ----------------------------------------------------------------------------
//   port         dir  handshake                    payload
//   instr        in   instr_valid / instr_stall    amx_pkg::instr_t
//   result       out  result_valid / result_stall  amx_pkg::result_t
//
// per instruction the back end reads operands from the synchronous word
// memory, then executes and writes back
// front register and a two word queue keep accepting while the back end works
// synchronous reset clears registers, write marks and queue; memory not cleared
// a stalled result holds the back end in execute; the front fills the queue
// ============================================================================
`default_nettype none

module accumulator_machine_executor_core (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             instr_valid,
  output logic                  instr_stall,
  input  wire amx_pkg::instr_t  instr,
  output logic                  result_valid,
  input  wire logic             result_stall,
  output amx_pkg::result_t      result
);

  logic             push;
  amx_pkg::item_t   push_item;
  logic             q_full;
  logic             pop;
  amx_pkg::q_head_t head;

  amx_front u_front (
    .clk         (clk),
    .rst         (rst),
    .instr_valid (instr_valid),
    .instr_stall (instr_stall),
    .instr       (instr),
    .push        (push),
    .push_item   (push_item),
    .q_full      (q_full)
  );

  amx_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .q_full    (q_full),
    .pop       (pop),
    .head      (head)
  );

  amx_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

`default_nettype wire

FILE: rtl/core/amx_front.sv
// ============================================================================
// amx_front
// accepts instruction words and classifies them into back end operations
// ============================================================================
`default_nettype none

module amx_front (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           instr_valid,
  output logic                instr_stall,
  input  wire amx_pkg::instr_t instr,
  output logic                push,
  output amx_pkg::item_t      push_item,
  input  wire logic           q_full
);

  logic           f_valid;
  logic           f_valid_next;
  amx_pkg::item_t f_item;
  amx_pkg::item_t dec_item;
  logic           accept;

  always_comb begin
    dec_item.addr_a    = instr.addr_a;
    dec_item.addr_b    = instr.addr_b;
    dec_item.addr_c    = instr.addr_c;
    dec_item.immediate = instr.immediate;
    dec_item.start     = instr.program_start;
    case (instr.cmd)
      amx_pkg::CMD_SET: dec_item.op = amx_pkg::OP_SET;
      amx_pkg::CMD_LDR: dec_item.op = amx_pkg::OP_LDR;
      amx_pkg::CMD_ADD: begin
        if (instr.operand_count == amx_pkg::CNT_THREE) begin
          dec_item.op = amx_pkg::OP_ADD3;
        end else if (instr.operand_count == amx_pkg::CNT_TWO) begin
          dec_item.op = amx_pkg::OP_ADD2;
        end else begin
          dec_item.op = amx_pkg::OP_ADD1;
        end
      end
      amx_pkg::CMD_INC: dec_item.op = amx_pkg::OP_INC;
      amx_pkg::CMD_DEC: dec_item.op = amx_pkg::OP_DEC;
      amx_pkg::CMD_STR: dec_item.op = amx_pkg::OP_STR;
      amx_pkg::CMD_SHW: begin
        case (instr.show_select)
          amx_pkg::SEL_ACC: dec_item.op = amx_pkg::OP_SHW_ACC;
          amx_pkg::SEL_MAR: dec_item.op = amx_pkg::OP_SHW_MAR;
          amx_pkg::SEL_MDR: dec_item.op = amx_pkg::OP_SHW_MDR;
          default:          dec_item.op = amx_pkg::OP_SHW_MEM;
        endcase
      end
      amx_pkg::CMD_END:   dec_item.op = amx_pkg::OP_END;
      amx_pkg::CMD_PAUSE: dec_item.op = amx_pkg::OP_NOP;
      default:            dec_item.op = amx_pkg::OP_NOP;
    endcase
  end

  assign instr_stall  = f_valid & q_full;
  assign accept       = instr_valid & ~instr_stall;
  assign push         = f_valid & ~q_full;
  assign push_item    = f_item;
  assign f_valid_next = accept | (f_valid & ~push);

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else begin
      f_valid <= f_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f_item <= dec_item;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/amx_queue.sv
// ============================================================================
// amx_queue
// short queue of classified operations between front and back end
// ============================================================================
`default_nettype none

module amx_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire amx_pkg::item_t push_item,
  output logic                q_full,
  input  wire logic           pop,
  output amx_pkg::q_head_t    head
);

  amx_pkg::item_t                 slots [amx_pkg::QDEPTH];
  logic [amx_pkg::QPTR_BITS-1:0]  wr_ptr;
  logic [amx_pkg::QPTR_BITS-1:0]  rd_ptr;
  logic [amx_pkg::QCNT_BITS-1:0]  count;
  logic [amx_pkg::QCNT_BITS-1:0]  count_next;

  assign q_full     = (count == amx_pkg::QCNT_BITS'(amx_pkg::QDEPTH));
  assign head.valid = (count != '0);
  assign head.item  = slots[rd_ptr];

  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + 1'b1;
    end else if (pop && !push) begin
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (push) begin
        wr_ptr <= (wr_ptr == amx_pkg::QPTR_BITS'(amx_pkg::QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == amx_pkg::QPTR_BITS'(amx_pkg::QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/amx_back.sv
// ============================================================================
// amx_back
// executes operations on the word memory and machine registers
// ============================================================================
`default_nettype none

module amx_back (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire amx_pkg::q_head_t head,
  output logic                  pop,
  output logic                  result_valid,
  input  wire logic             result_stall,
  output amx_pkg::result_t      result
);

  localparam int AB = amx_pkg::ADDR_BITS;
  localparam int DB = amx_pkg::DATA_BITS;

  logic [DB-1:0]     mem [amx_pkg::MEM_WORDS];
  logic [amx_pkg::MEM_WORDS-1:0] marks;

  amx_pkg::bk_state_t state;
  amx_pkg::bk_state_t state_next;
  amx_pkg::item_t     it;
  logic [DB-1:0]      rd_a;
  logic [DB-1:0]      rd_b;

  logic [DB-1:0]              acc;
  logic [7:0]                 mar;
  logic [DB-1:0]              mdr;
  logic [amx_pkg::PC_BITS-1:0] pc;
  logic                       halt;

  logic [DB-1:0]              acc_next;
  logic [7:0]                 mar_next;
  logic [DB-1:0]              mdr_next;
  logic [amx_pkg::PC_BITS-1:0] pc_next;
  logic                       halt_next;

  logic          done;
  logic          out_free;
  logic          halt_eff;
  logic          mark_a;
  logic          mark_b;
  logic [DB-1:0] x;
  logic [DB-1:0] y;
  logic [DB-1:0] sum;
  logic          we;
  logic [7:0]    wa;
  logic [DB-1:0] wd;
  logic          sv;
  logic [DB-1:0] show;

  assign out_free = ~result_valid | ~result_stall;

  // sequencer
  always_comb begin
    state_next = state;
    pop        = 1'b0;
    done       = 1'b0;
    case (state)
      amx_pkg::BK_IDLE: begin
        if (head.valid) begin
          pop        = 1'b1;
          state_next = amx_pkg::BK_EXEC;
        end
      end
      amx_pkg::BK_EXEC: begin
        if (out_free) begin
          done       = 1'b1;
          state_next = amx_pkg::BK_IDLE;
        end
      end
      default: state_next = amx_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= amx_pkg::BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // operand fetch and memory write back
  always_ff @(posedge clk) begin
    if (pop) begin
      it   <= head.item;
      rd_a <= mem[head.item.addr_a[AB-1:0]];
      rd_b <= mem[head.item.addr_b[AB-1:0]];
    end
    if (done && we) begin
      mem[wa[AB-1:0]] <= wd;
    end
  end

  // execute
  always_comb begin
    halt_eff  = halt & ~it.start;
    mark_a    = ~it.start & marks[it.addr_a[AB-1:0]];
    mark_b    = ~it.start & marks[it.addr_b[AB-1:0]];
    x         = mark_a ? rd_a : '0;
    y         = mark_b ? rd_b : '0;
    sum       = x + y;
    acc_next  = acc;
    mar_next  = mar;
    mdr_next  = mdr;
    pc_next   = it.start ? '0 : pc;
    halt_next = halt_eff;
    we        = 1'b0;
    wa        = it.addr_a;
    wd        = it.immediate;
    sv        = 1'b0;
    show      = '0;
    if (!halt_eff) begin
      pc_next = pc_next + 1'b1;
      case (it.op)
        amx_pkg::OP_SET: begin
          we       = 1'b1;
          mar_next = it.addr_a;
          mdr_next = it.immediate;
        end
        amx_pkg::OP_LDR: begin
          mar_next = it.addr_a;
          mdr_next = x;
          acc_next = x;
        end
        amx_pkg::OP_ADD1: begin
          mar_next = it.addr_a;
          mdr_next = x;
          acc_next = acc + x;
        end
        amx_pkg::OP_ADD2: begin
          mar_next = it.addr_b;
          mdr_next = y;
          acc_next = sum;
        end
        amx_pkg::OP_ADD3: begin
          mar_next = it.addr_c;
          mdr_next = sum;
          acc_next = sum;
          we       = 1'b1;
          wa       = it.addr_c;
          wd       = sum;
        end
        amx_pkg::OP_INC: begin
          mar_next = it.addr_a;
          mdr_next = x + 1'b1;
          we       = 1'b1;
          wd       = x + 1'b1;
        end
        amx_pkg::OP_DEC: begin
          mar_next = it.addr_a;
          mdr_next = x - 1'b1;
          we       = 1'b1;
          wd       = x - 1'b1;
        end
        amx_pkg::OP_STR: begin
          mar_next = it.addr_a;
          mdr_next = acc;
          we       = 1'b1;
          wd       = acc;
        end
        amx_pkg::OP_SHW_ACC: begin
          sv   = 1'b1;
          show = acc;
        end
        amx_pkg::OP_SHW_MAR: begin
          sv   = 1'b1;
          show = DB'(mar);
        end
        amx_pkg::OP_SHW_MDR: begin
          sv   = 1'b1;
          show = mdr;
        end
        amx_pkg::OP_SHW_MEM: begin
          sv       = 1'b1;
          show     = x;
          mar_next = it.addr_a;
        end
        amx_pkg::OP_END: halt_next = 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc          <= '0;
      mar          <= '0;
      mdr          <= '0;
      pc           <= '0;
      halt         <= 1'b0;
      marks        <= '0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= done | (result_valid & result_stall);
      if (done) begin
        acc   <= acc_next;
        mar   <= mar_next;
        mdr   <= mdr_next;
        pc    <= pc_next;
        halt  <= halt_next;
        marks <= (it.start ? '0 : marks) |
                 ({{(amx_pkg::MEM_WORDS-1){1'b0}}, we} << wa[AB-1:0]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      result.accumulator <= acc_next;
      result.address_reg <= mar_next;
      result.data_reg    <= mdr_next;
      result.show_valid  <= sv;
      result.show_value  <= show;
      result.halted      <= halt_next;
      result.instr_count <= pc_next;
    end
  end

  a_pop_from_idle: assert property (@(posedge clk) disable iff (rst)
    pop |-> state == amx_pkg::BK_IDLE)
    else $error("queue popped while executing");

  a_pop_then_exec: assert property (@(posedge clk) disable iff (rst)
    pop |=> state == amx_pkg::BK_EXEC)
    else $error("popped operation not executed");

  a_done_loads_out: assert property (@(posedge clk) disable iff (rst)
    done |=> result_valid)
    else $error("finished operation left no result");

  a_halt_keeps_pc: assert property (@(posedge clk) disable iff (rst)
    (done && halt && !it.start) |=> $stable(pc))
    else $error("program counter moved while halted");

endmodule

`default_nettype wire

FILE: tb/sv/tb.sv
// ============================================================================
// tb
// self-checking bench for accumulator_machine_executor_core: directed corner
// programs, then random programs under random sender gaps and receiver stalls;
// a scoreboard class mirrors the machine state and checks every result word
// ============================================================================
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import amx_pkg::*;

  localparam logic [3:0] CMD_BAD = 4'hF;
  localparam int LIMIT = 600000;
  localparam int ITEMS = 1400;

  class exec_scoreboard;
    logic [DATA_BITS-1:0] words [MEM_WORDS];
    bit                   marked [MEM_WORDS];
    logic [DATA_BITS-1:0] acc;
    logic [DATA_BITS-1:0] mdr;
    logic [7:0]           mar;
    logic [PC_BITS-1:0]   pc;
    bit                   halt;
    result_t              expected_results [$];
    int                   errors;
    int                   checked;

    function new();
      foreach (words[i]) begin
        words[i] = '0;
        marked[i] = 1'b0;
      end
      acc = '0;
      mdr = '0;
      mar = '0;
      pc = '0;
      halt = 1'b0;
      errors = 0;
      checked = 0;
    endfunction

    function logic [DATA_BITS-1:0] load(logic [7:0] a);
      return marked[a] ? words[a] : '0;
    endfunction

    function void save(logic [7:0] a, logic [DATA_BITS-1:0] v);
      words[a] = v;
      marked[a] = 1'b1;
    endfunction

    function void note_instr(instr_t w);
      result_t              r;
      logic [DATA_BITS-1:0] x;
      logic [DATA_BITS-1:0] y;
      logic [DATA_BITS-1:0] shown;
      r = '0;
      shown = '0;
      if (w.program_start) begin
        foreach (marked[i]) marked[i] = 1'b0;
        pc = '0;
        halt = 1'b0;
      end
      if (!halt) begin
        pc = pc + 1'b1;
        case (w.cmd)
          CMD_SET: begin
            save(w.addr_a, w.immediate);
            mar = w.addr_a;
            mdr = w.immediate;
          end
          CMD_LDR: begin
            mar = w.addr_a;
            mdr = load(w.addr_a);
            acc = mdr;
          end
          CMD_ADD: begin
            if (w.operand_count == CNT_TWO || w.operand_count == CNT_THREE) begin
              x = load(w.addr_a);
              y = load(w.addr_b);
              acc = x + y;
              mar = w.addr_b;
              mdr = y;
              if (w.operand_count == CNT_THREE) begin
                mar = w.addr_c;
                mdr = acc;
                save(w.addr_c, acc);
              end
            end else begin
              mar = w.addr_a;
              mdr = load(w.addr_a);
              acc = acc + mdr;
            end
          end
          CMD_INC, CMD_DEC: begin
            mar = w.addr_a;
            x = load(w.addr_a);
            mdr = (w.cmd == CMD_INC) ? x + 1'b1 : x - 1'b1;
            save(w.addr_a, mdr);
          end
          CMD_STR: begin
            mar = w.addr_a;
            mdr = acc;
            save(w.addr_a, acc);
          end
          CMD_SHW: begin
            r.show_valid = 1'b1;
            case (w.show_select)
              SEL_ACC: shown = acc;
              SEL_MAR: shown = DATA_BITS'(mar);
              SEL_MDR: shown = mdr;
              default: begin
                mar = w.addr_a;
                shown = load(w.addr_a);
              end
            endcase
          end
          CMD_END: halt = 1'b1;
          default: ;
        endcase
      end
      r.accumulator = acc;
      r.address_reg = mar;
      r.data_reg = mdr;
      r.show_value = shown;
      r.halted = halt;
      r.instr_count = pc;
      expected_results = {expected_results, r};
    endfunction

    task report(string what, logic [DATA_BITS-1:0] got, logic [DATA_BITS-1:0] want);
      errors++;
      if (errors <= 40)
        $display("mismatch %0s: got %h want %h at result %0d", what, got, want, checked);
    endtask

    task check_result(result_t got);
      result_t want;
      if (expected_results.size() == 0) begin
        report("unexpected word", '0, '0);
        return;
      end
      want = expected_results.pop_front();
      if (got.accumulator !== want.accumulator)
        report("accumulator", got.accumulator, want.accumulator);
      if (got.address_reg !== want.address_reg)
        report("address_reg", DATA_BITS'(got.address_reg), DATA_BITS'(want.address_reg));
      if (got.data_reg !== want.data_reg)
        report("data_reg", got.data_reg, want.data_reg);
      if (got.show_valid !== want.show_valid)
        report("show_valid", DATA_BITS'(got.show_valid), DATA_BITS'(want.show_valid));
      if (got.show_value !== want.show_value)
        report("show_value", got.show_value, want.show_value);
      if (got.halted !== want.halted)
        report("halted", DATA_BITS'(got.halted), DATA_BITS'(want.halted));
      if (got.instr_count !== want.instr_count)
        report("instr_count", DATA_BITS'(got.instr_count), DATA_BITS'(want.instr_count));
      checked++;
    endtask
  endclass

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    instr_valid = 1'b0;
  logic    instr_stall;
  instr_t  instr = '0;
  logic    result_valid;
  logic    result_stall = 1'b0;
  result_t result;

  exec_scoreboard sb = new();

  bit         seeded [MEM_WORDS];
  logic [7:0] seeded_list [$];
  bit         gen_halted;
  bit         quiet;
  int         issued;
  int         cycles;

  accumulator_machine_executor_core u_dut (
    .clk          (clk),
    .rst          (rst),
    .instr_valid  (instr_valid),
    .instr_stall  (instr_stall),
    .instr        (instr),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && instr_valid && !instr_stall) sb.note_instr(instr);
    if (!rst && result_valid && !result_stall) sb.check_result(result);
  end

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] pick_read();
    logic [7:0] a;
    a = 8'($urandom);
    if (!seeded[a]) a = seeded_list[$urandom_range(0, seeded_list.size() - 1)];
    return a;
  endfunction

  function automatic void note_seed(logic [7:0] a);
    if (!seeded[a]) begin
      seeded[a] = 1'b1;
      seeded_list = {seeded_list, a};
    end
  endfunction

  function automatic instr_t op(logic [3:0] cmd, logic [7:0] a, logic [7:0] b,
                                logic [7:0] c, logic [1:0] cnt,
                                logic [DATA_BITS-1:0] imm, logic [1:0] sel,
                                logic start);
    instr_t w;
    w.cmd = cmd;
    w.addr_a = a;
    w.addr_b = b;
    w.addr_c = c;
    w.operand_count = cnt;
    w.immediate = imm;
    w.show_select = sel;
    w.program_start = start;
    return w;
  endfunction

  function automatic instr_t make_item(logic start);
    instr_t w;
    int     r;
    bit     rd_a;
    bit     rd_b;
    r = $urandom_range(0, 99);
    if (r < 90) w.cmd = 4'($urandom_range(0, 7));
    else if (r < 94) w.cmd = CMD_END;
    else w.cmd = 4'($urandom_range(9, 15));
    w.addr_a = 8'($urandom);
    w.addr_b = 8'($urandom);
    w.addr_c = 8'($urandom);
    w.operand_count = 2'($urandom);
    r = $urandom_range(0, 99);
    if (r < 8) w.immediate = 32'h8000_0000;
    else if (r < 16) w.immediate = 32'h7FFF_FFFF;
    else if (r < 22) w.immediate = 32'hFFFF_FFFF;
    else w.immediate = $urandom;
    w.show_select = 2'($urandom);
    w.program_start = start;
    rd_a = (w.cmd == CMD_LDR || w.cmd == CMD_ADD || w.cmd == CMD_INC ||
            w.cmd == CMD_DEC || (w.cmd == CMD_SHW && w.show_select == SEL_MEM));
    rd_b = (w.cmd == CMD_ADD &&
            (w.operand_count == CNT_TWO || w.operand_count == CNT_THREE));
    if ((rd_a || rd_b) && seeded_list.size() == 0) begin
      w.cmd = CMD_SET;
    end else begin
      if (rd_a) w.addr_a = pick_read();
      if (rd_b) w.addr_b = pick_read();
    end
    return w;
  endfunction

  task automatic drive_instr(input instr_t w);
    int n;
    instr <= w;
    instr_valid <= 1'b1;
    @(posedge clk);
    while (instr_stall) @(posedge clk);
    n = quiet ? 0 : idle_len();
    if (n > 0) begin
      instr_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // track what the machine will really write, so reads aim at written words (a restart does not clear this record)
  task automatic issue(input instr_t w);
    if (w.program_start) gen_halted = 1'b0;
    issued++;
    if (!gen_halted) begin
      case (w.cmd)
        CMD_SET, CMD_INC, CMD_DEC, CMD_STR: note_seed(w.addr_a);
        CMD_ADD: if (w.operand_count == CNT_THREE) note_seed(w.addr_c);
        CMD_END: gen_halted = 1'b1;
        default: ;
      endcase
    end
    drive_instr(w);
  endtask

  task automatic wait_drained();
    instr_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_results.size() != 0) @(posedge clk);
  endtask

  initial begin
    int n;
    forever begin
      @(posedge clk);
      n = quiet ? 0 : idle_len();
      if (n > 0) begin
        result_stall <= 1'b1;
        repeat (n) @(posedge clk);
        result_stall <= 1'b0;
      end
    end
  end

  initial begin
    int     i;
    int     plen;
    int     progs;
    instr_t w;
    logic   start;
    progs = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // corner program: extremes, wraps, every op and show target
    issue(op(CMD_SET, 8'h00, 8'h00, 8'h00, 2'd1, 32'h8000_0000, SEL_ACC, 1'b1));
    issue(op(CMD_SET, 8'hFF, 8'h00, 8'h00, 2'd1, 32'h7FFF_FFFF, SEL_ACC, 1'b0));
    issue(op(CMD_SET, 8'h55, 8'h00, 8'h00, 2'd1, 32'hFFFF_FFFF, SEL_ACC, 1'b0));
    issue(op(CMD_SET, 8'hAA, 8'h00, 8'h00, 2'd1, 32'h0000_0000, SEL_ACC, 1'b0));
    issue(op(CMD_LDR, 8'hFF, 8'h00, 8'h00, 2'd1, '0, SEL_ACC, 1'b0));
    issue(op(CMD_ADD, 8'hFF, 8'hAA, 8'h55, 2'd1, '0, SEL_ACC, 1'b0));
    issue(op(CMD_ADD, 8'h00, 8'hFF, 8'hFF, 2'd0, '0, SEL_ACC, 1'b0));
    issue(op(CMD_ADD, 8'hFF, 8'h00, 8'h00, CNT_TWO, '0, SEL_ACC, 1'b0));
    issue(op(CMD_ADD, 8'hFF, 8'hFF, 8'hAA, CNT_THREE, '0, SEL_ACC, 1'b0));
    issue(op(CMD_INC, 8'hFF, 8'h00, 8'h00, 2'd1, '0, SEL_ACC, 1'b0));
    issue(op(CMD_DEC, 8'h00, 8'h00, 8'h00, 2'd1, '0, SEL_ACC, 1'b0));
    issue(op(CMD_INC, 8'h55, 8'h00, 8'h00, 2'd1, '0, SEL_ACC, 1'b0));
    issue(op(CMD_STR, 8'h55, 8'h00, 8'h00, 2'd1, '0, SEL_ACC, 1'b0));
    issue(op(CMD_SHW, 8'h00, 8'h00, 8'h00, 2'd1, '0, SEL_ACC, 1'b0));
    issue(op(CMD_SHW, 8'h00, 8'h00, 8'h00, 2'd1, '0, SEL_MAR, 1'b0));
    issue(op(CMD_SHW, 8'h00, 8'h00, 8'h00, 2'd1, '0, SEL_MDR, 1'b0));
    issue(op(CMD_SHW, 8'hAA, 8'h00, 8'h00, 2'd1, '0, SEL_MEM, 1'b0));
    issue(op(CMD_PAUSE, 8'h12, 8'h34, 8'h56, 2'd3, '1, SEL_MEM, 1'b0));
    issue(op(CMD_BAD, 8'h12, 8'h34, 8'h56, 2'd3, '1, SEL_MDR, 1'b0));
    issue(op(CMD_END, 8'h00, 8'h00, 8'h00, 2'd1, '0, SEL_ACC, 1'b0));
    // halted: ignored until the next start
    issue(op(CMD_SHW, 8'hFF, 8'h00, 8'h00, 2'd1, '0, SEL_MEM, 1'b0));
    issue(op(CMD_SET, 8'h10, 8'h00, 8'h00, 2'd1, 32'h1234_5678, SEL_ACC, 1'b0));
    // restart clears write marks
    issue(op(CMD_LDR, 8'hFF, 8'h00, 8'h00, 2'd1, '0, SEL_ACC, 1'b1));
    issue(op(CMD_SHW, 8'h00, 8'h00, 8'h00, 2'd1, '0, SEL_MEM, 1'b0));
    issue(op(CMD_SET, 8'h00, 8'h00, 8'h00, 2'd1, 32'h0000_0005, SEL_ACC, 1'b0));
    issue(op(CMD_LDR, 8'h00, 8'h00, 8'h00, 2'd1, '0, SEL_ACC, 1'b0));
    issue(op(CMD_END, 8'h00, 8'h00, 8'h00, 2'd1, '0, SEL_ACC, 1'b1));
    wait_drained();

    while (issued < ITEMS) begin
      quiet = ($urandom_range(0, 5) == 0);
      plen = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120) : $urandom_range(2, 24);
      for (i = 0; i < plen; i++) begin
        start = (i == 0) ? ($urandom_range(0, 19) != 0) : ($urandom_range(0, 199) == 0);
        issue(make_item(start));
      end
      if ($urandom_range(0, 99) < 85) begin
        w = make_item(1'b0);
        w.cmd = CMD_END;
        issue(w);
      end
      repeat ($urandom_range(0, 2)) issue(make_item(1'b0));
      progs++;
      if (progs % 10 == 0) wait_drained();
    end
    quiet = 1'b0;

    wait_drained();
    repeat (16) @(posedge clk);
    if (sb.errors == 0 && sb.expected_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire
